>>> rtl/core/vtm_pkg.sv
// Shared types and constants for the vote tally mode finder.
package vtm_pkg;

    localparam int VOTE_W            = 16;
    localparam int COUNT_W           = 16;
    localparam int DISTINCT_W        = 7;
    localparam int TABLE_ENTRIES_DEF = 64;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RD,
        ST_CMP,
        ST_INS,
        ST_TAIL,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_OUT
    } vtm_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch_in;   // capture the incoming transaction
        logic idx_clr;    // restart the table walk at entry 0
        logic idx_inc;    // step to the next entry
        logic wr_match;   // bump the count of the matched entry
        logic wr_insert;  // store the vote as a new entry
        logic set_ovf;    // table full, drop the rest of the batch
        logic scan_cmp;   // argmax compare of the entry just read
        logic out_load;   // register the result and empty the table
    } vtm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic present;
        logic closing;
        logic ovf;
        logic used_zero;
        logic last_idx;
        logic key_match;
        logic table_full;
    } vtm_status_t;

endpackage

>>> rtl/core/vote_tally_mode_finder.sv
// Top level of the vote tally mode finder: controller plus datapath.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+--------------------------------------------
//  vote in  | start high, busy low | vote_value, vote_present, end_of_batch
//  result   | done, one cycle    | winner_value, winner_count, distinct_values,
//           |                    | batch_empty, table_overflow
//
//  A vote walks the stored entries through the table RAM's single read port,
//  with a read state and a compare state for each entry compared, visiting up
//  to the fill count of entries. A closing transaction adds a full argmax pass
//  over the stored entries and a state that loads the result, which is strobed
//  on done in the cycle after that load.
//  Reset is asynchronous and clears only control state; the table needs no
//  clearing pass. The result is registered and shown on done for one cycle;
//  the receiver cannot stall it, and a new transaction may start meanwhile.
module vote_tally_mode_finder #(
    parameter int TABLE_ENTRIES = vtm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [vtm_pkg::VOTE_W-1:0]     vote_value,
    input  logic                           vote_present,
    input  logic                           end_of_batch,
    output logic                           done,
    output logic [vtm_pkg::VOTE_W-1:0]     winner_value,
    output logic [vtm_pkg::COUNT_W-1:0]    winner_count,
    output logic [vtm_pkg::DISTINCT_W-1:0] distinct_values,
    output logic                           batch_empty,
    output logic                           table_overflow
);

    import vtm_pkg::*;

    vtm_cmd_t    cmd;
    vtm_status_t status;

    vtm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    vtm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .vote_value      (vote_value),
        .vote_present    (vote_present),
        .end_of_batch    (end_of_batch),
        .cmd             (cmd),
        .status          (status),
        .winner_value    (winner_value),
        .winner_count    (winner_count),
        .distinct_values (distinct_values),
        .batch_empty     (batch_empty),
        .table_overflow  (table_overflow),
        .done            (done)
    );

endmodule

>>> rtl/core/vtm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module vtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/vtm_ctrl.sv
// Controller state machine: sequences table walk, insert and final argmax scan.
module vtm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  vtm_pkg::vtm_status_t status,
    output vtm_pkg::vtm_cmd_t    cmd
);

    import vtm_pkg::*;

    vtm_state_t state_reg;
    vtm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.present && !status.ovf)
                begin
                    state_next = status.used_zero ? ST_INS : ST_RD;
                end
                else
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.key_match)
                begin
                    state_next = ST_TAIL;
                end
                else if (status.last_idx)
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_INS:
            begin
                state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                if (!status.closing)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.used_zero)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                state_next = status.last_idx ? ST_OUT : ST_SCAN_RD;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                cmd.latch_in = start;
                cmd.idx_clr  = start;
            end
            ST_DECIDE:
            begin
            end
            ST_RD:
            begin
            end
            ST_CMP:
            begin
                cmd.wr_match = status.key_match;
                cmd.idx_inc  = !status.key_match && !status.last_idx;
            end
            ST_INS:
            begin
                cmd.set_ovf   = status.table_full;
                cmd.wr_insert = !status.table_full;
            end
            ST_TAIL:
            begin
                cmd.idx_clr = 1'b1;
            end
            ST_SCAN_RD:
            begin
            end
            ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                cmd.idx_inc  = !status.last_idx;
            end
            ST_OUT:
            begin
                cmd.out_load = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // a compare always follows the read that fetched its entry
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP || state_reg == ST_SCAN_CMP) |->
        ($past(state_reg) == ST_RD || $past(state_reg) == ST_SCAN_RD))
        else $error("compare state without preceding read");

    // a result is produced only at the end of a closing transaction
    a_out_from_tail_or_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |->
        ($past(state_reg) == ST_TAIL || $past(state_reg) == ST_SCAN_CMP))
        else $error("result state entered out of sequence");

endmodule

>>> rtl/core/vtm_dp.sv
// Datapath: input capture, tally RAM, walk index, argmax registers, result registers.
module vtm_dp #(
    parameter int TABLE_ENTRIES = vtm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [vtm_pkg::VOTE_W-1:0]        vote_value,
    input  logic                              vote_present,
    input  logic                              end_of_batch,
    input  vtm_pkg::vtm_cmd_t                 cmd,
    output vtm_pkg::vtm_status_t              status,
    output logic [vtm_pkg::VOTE_W-1:0]        winner_value,
    output logic [vtm_pkg::COUNT_W-1:0]       winner_count,
    output logic [vtm_pkg::DISTINCT_W-1:0]    distinct_values,
    output logic                              batch_empty,
    output logic                              table_overflow,
    output logic                              done
);

    import vtm_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = VOTE_W + COUNT_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // captured transaction
    logic [VOTE_W-1:0] vote_reg;
    logic              present_reg;
    logic              closing_reg;

    // batch state
    logic [CNT_W-1:0]  used_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_plus;

    // argmax
    logic [VOTE_W-1:0]  best_val_reg;
    logic [COUNT_W-1:0] best_cnt_reg;

    // result registers
    logic [VOTE_W-1:0]     winner_value_reg;
    logic [COUNT_W-1:0]    winner_count_reg;
    logic [DISTINCT_W-1:0] distinct_reg;
    logic                  empty_reg;
    logic                  ovf_out_reg;
    logic                  done_reg;

    // RAM interface
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [VOTE_W-1:0]  rd_key;
    logic [COUNT_W-1:0] rd_cnt;
    logic [COUNT_W-1:0] cnt_inc;

    assign rd_key   = ram_rdata[ENTRY_W-1:COUNT_W];
    assign rd_cnt   = ram_rdata[COUNT_W-1:0];
    assign cnt_inc  = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
    assign idx_plus = idx_reg + CNT_W'(1);

    // one table entry holds {key, count}
    vtm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // write mux: bump on match, new entry on insert
    always_comb
    begin
        ram_we    = cmd.wr_match || cmd.wr_insert;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = {vote_reg, cnt_inc};
        if (cmd.wr_insert)
        begin
            ram_waddr = used_reg[IDX_W-1:0];
            ram_wdata = {vote_reg, COUNT_W'(1)};
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            vote_reg    <= vote_value;
            present_reg <= vote_present;
            closing_reg <= end_of_batch;
        end
    end

    // walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_plus;
        end
    end

    // fill count and overflow flag, cleared when the result goes out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            used_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_insert)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // running argmax, strict greater keeps the earliest entry on ties
    always_ff @(posedge clk)
    begin
        if (cmd.scan_cmp && (idx_reg == '0 || rd_cnt > best_cnt_reg))
        begin
            best_val_reg <= rd_key;
            best_cnt_reg <= rd_cnt;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            winner_value_reg <= (used_reg == '0) ? '0 : best_val_reg;
            winner_count_reg <= (used_reg == '0) ? '0 : best_cnt_reg;
            distinct_reg     <= DISTINCT_W'(used_reg);
            empty_reg        <= (used_reg == '0);
            ovf_out_reg      <= ovf_reg;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.out_load;
        end
    end

    // status to controller
    always_comb
    begin
        status.present    = present_reg;
        status.closing    = closing_reg;
        status.ovf        = ovf_reg;
        status.used_zero  = (used_reg == '0);
        status.last_idx   = (idx_plus == used_reg);
        status.key_match  = (rd_key == vote_reg);
        status.table_full = (used_reg == CNT_W'(TABLE_ENTRIES));
    end

    assign winner_value    = winner_value_reg;
    assign winner_count    = winner_count_reg;
    assign distinct_values = distinct_reg;
    assign batch_empty     = empty_reg;
    assign table_overflow  = ovf_out_reg;
    assign done            = done_reg;

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // a new entry is only written into free space
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_insert |-> (used_reg < CNT_W'(TABLE_ENTRIES)) && !ovf_reg)
        else $error("insert into full table");

    // the table is empty while the result is shown
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (used_reg == '0) && !ovf_reg)
        else $error("table not cleared after result");

    // the walk index stays inside the filled part of the table
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_match || cmd.scan_cmp) |-> (idx_reg < used_reg))
        else $error("table walk past the last entry");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the vote tally mode finder.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import vtm_pkg::*;

    localparam int ENTRIES     = TABLE_ENTRIES_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 300;
    localparam int RAND_ITEMS  = 1600;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VOTE_W-1:0]     vote_value;
    logic                  vote_present;
    logic                  end_of_batch;
    logic                  done;
    logic [VOTE_W-1:0]     winner_value;
    logic [COUNT_W-1:0]    winner_count;
    logic [DISTINCT_W-1:0] distinct_values;
    logic                  batch_empty;
    logic                  table_overflow;

    // One batch result as the block reports it
    typedef struct {
        logic [VOTE_W-1:0]     value;
        logic [COUNT_W-1:0]    count;
        logic [DISTINCT_W-1:0] distinct;
        logic                  empty;
        logic                  overflow;
    } winner_t;

    // Tally model of the block plus the queue of winners still owed
    class vote_tally_tracker;
        logic [VOTE_W-1:0]  keys[ENTRIES];
        logic [COUNT_W-1:0] counts[ENTRIES];
        int unsigned        used;
        bit                 dropping;
        winner_t            expected_winners[$];
        int unsigned        mismatches;
        int unsigned        results_checked;

        function new();
            used            = 0;
            dropping        = 1'b0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function int unsigned pending();
            return expected_winners.size();
        endfunction

        // Count one vote; after an overflow the rest of the batch is dropped
        function void tally(logic [VOTE_W-1:0] v);
            if (dropping)
                return;
            for (int k = 0; k < used; k++)
            begin
                if (keys[k] == v)
                begin
                    if (counts[k] != '1)
                        counts[k]++;
                    return;
                end
            end
            if (used >= ENTRIES)
            begin
                dropping = 1'b1;
                return;
            end
            keys[used]   = v;
            counts[used] = 1;
            used++;
        endfunction

        // Accepted transaction: tally, then form the winner on a closing one
        function void note_vote(logic [VOTE_W-1:0] v, logic present, logic closing);
            winner_t w;
            if (present)
                tally(v);
            if (!closing)
                return;
            w.value    = '0;
            w.count    = '0;
            if (used > 0)
            begin
                w.value = keys[0];
                w.count = counts[0];
                // strict compare keeps the earliest entry on ties
                for (int k = 1; k < used; k++)
                begin
                    if (counts[k] > w.count)
                    begin
                        w.value = keys[k];
                        w.count = counts[k];
                    end
                end
            end
            w.distinct = used[DISTINCT_W-1:0];
            w.empty    = (used == 0);
            w.overflow = dropping;
            expected_winners.push_back(w);
            used     = 0;
            dropping = 1'b0;
        endfunction

        // Compare one strobed result against the oldest expected winner
        function void check_winner(winner_t got);
            winner_t exp_w;
            if (expected_winners.size() == 0)
            begin
                $error("result strobed with no batch closed: value %0h count %0d",
                       got.value, got.count);
                mismatches++;
                return;
            end
            exp_w = expected_winners.pop_front();
            results_checked++;
            if (got.value !== exp_w.value)
            begin
                $error("winner_value: expected %0h, got %0h", exp_w.value, got.value);
                mismatches++;
            end
            if (got.count !== exp_w.count)
            begin
                $error("winner_count: expected %0d, got %0d", exp_w.count, got.count);
                mismatches++;
            end
            if (got.distinct !== exp_w.distinct)
            begin
                $error("distinct_values: expected %0d, got %0d",
                       exp_w.distinct, got.distinct);
                mismatches++;
            end
            if (got.empty !== exp_w.empty)
            begin
                $error("batch_empty: expected %0b, got %0b", exp_w.empty, got.empty);
                mismatches++;
            end
            if (got.overflow !== exp_w.overflow)
            begin
                $error("table_overflow: expected %0b, got %0b",
                       exp_w.overflow, got.overflow);
                mismatches++;
            end
        endfunction
    endclass

    vote_tally_tracker tracker;
    int unsigned       idle_pct;
    int unsigned       rand_items;
    int unsigned       batches_sent;
    int unsigned       quiet_cycles;

    vote_tally_mode_finder u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .vote_value      (vote_value),
        .vote_present    (vote_present),
        .end_of_batch    (end_of_batch),
        .done            (done),
        .winner_value    (winner_value),
        .winner_count    (winner_count),
        .distinct_values (distinct_values),
        .batch_empty     (batch_empty),
        .table_overflow  (table_overflow)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Monitor: note accepted transactions and check strobed results
    always @(posedge clk)
    begin
        winner_t got;
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_vote(vote_value, vote_present, end_of_batch);
            if (done)
            begin
                got.value    = winner_value;
                got.count    = winner_count;
                got.distinct = distinct_values;
                got.empty    = batch_empty;
                got.overflow = table_overflow;
                tracker.check_winner(got);
            end
        end
    end

    // Watchdog on cycles with no transaction and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: no progress for %0d cycles", QUIET_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Present one transaction, hold it until accepted, then maybe idle
    task automatic send_vote(input logic [VOTE_W-1:0] v, input logic present,
                             input logic closing);
        start        <= 1'b1;
        vote_value   <= v;
        vote_present <= present;
        end_of_batch <= closing;
        do
            @(posedge clk);
        while (busy);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start        <= 1'b0;
            vote_value   <= VOTE_W'($urandom);
            vote_present <= 1'($urandom);
            end_of_batch <= 1'($urandom);
            @(posedge clk);
        end
    endtask

    // Hold the sender off until every closed batch has reported
    task automatic wait_results_in();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // One random batch: mostly well-formed, sometimes a table-filling one or noise
    task automatic random_batch();
        logic [VOTE_W-1:0] pool[$];
        logic [VOTE_W-1:0] v;
        int unsigned       kind;
        int unsigned       len;
        int unsigned       pool_n;
        logic              present;
        logic              closing;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            // small pool so repeats and ties are common
            pool_n = $urandom_range(1, 8);
            for (int i = 0; i < pool_n; i++)
            begin
                case ($urandom_range(7))
                    0:       pool.push_back('0);
                    1:       pool.push_back('1);
                    default: pool.push_back(VOTE_W'($urandom));
                endcase
            end
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
            begin
                v       = pool[$urandom_range(pool_n - 1)];
                present = ($urandom_range(9) != 0);
                closing = (i == len - 1);
                send_vote(v, present, closing);
                rand_items++;
            end
        end
        else if (kind < 83)
        begin
            // mostly distinct values, so the table may fill and spill over
            len = $urandom_range(66, 90);
            for (int i = 0; i < len; i++)
            begin
                if (pool.size() != 0 && $urandom_range(3) == 0)
                    v = pool[$urandom_range(pool.size() - 1)];
                else
                    v = VOTE_W'($urandom);
                pool.push_back(v);
                closing = (i == len - 1);
                send_vote(v, 1'b1, closing);
                rand_items++;
            end
        end
        else
        begin
            // noise: short, random markers, possibly empty
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
            begin
                present = 1'($urandom);
                send_vote(VOTE_W'($urandom), present, 1'b0);
                rand_items++;
            end
            send_vote(VOTE_W'($urandom), 1'($urandom), 1'b1);
            rand_items++;
        end
        batches_sent++;
    endtask

    // Stimulus
    initial
    begin
        int unsigned phase_pct[4];
        int unsigned phase_goal;
        logic [VOTE_W-1:0] fill_key[ENTRIES];
        tracker      = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        vote_value   = '0;
        vote_present = 1'b0;
        end_of_batch = 1'b0;
        idle_pct     = 0;
        rand_items   = 0;
        batches_sent = 0;
        quiet_cycles = 0;
        phase_pct    = '{0, 81, 0, 31};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty batch: only a closing marker
        send_vote(16'h1234, 1'b0, 1'b1);
        // vote on the closing transaction itself
        send_vote(16'hFFFF, 1'b1, 1'b1);
        // tie: first stored value wins, marker in between is not counted
        send_vote(16'h0000, 1'b1, 1'b0);
        send_vote(16'h8001, 1'b1, 1'b0);
        send_vote(16'h8001, 1'b1, 1'b0);
        send_vote(16'h0000, 1'b1, 1'b0);
        send_vote(16'h8001, 1'b0, 1'b0);
        send_vote(16'h7FFE, 1'b0, 1'b1);
        // a later value with a larger count takes over
        send_vote(16'h0005, 1'b1, 1'b0);
        send_vote(16'h0007, 1'b1, 1'b0);
        send_vote(16'h0007, 1'b1, 1'b1);
        wait_results_in();

        // full table: match still counts, new value overflows, rest dropped
        for (int k = 0; k < ENTRIES; k++)
        begin
            fill_key[k] = VOTE_W'(k * 1031 + 17);
            send_vote(fill_key[k], 1'b1, 1'b0);
        end
        send_vote(fill_key[10], 1'b1, 1'b0);
        send_vote(16'hFFFF, 1'b1, 1'b0);
        send_vote(fill_key[10], 1'b1, 1'b0);
        send_vote(fill_key[20], 1'b1, 1'b0);
        send_vote(16'h0000, 1'b1, 1'b1);
        // table must be empty again for the next batch
        send_vote(16'h0003, 1'b1, 1'b1);
        wait_results_in();
        batches_sent = 6;

        // random batches over the sender idling phases
        for (int p = 0; p < 4; p++)
        begin
            phase_goal = RAND_ITEMS * (p + 1) / 4;
            while (rand_items < phase_goal)
            begin
                idle_pct = ($urandom_range(4) == 0) ? 0 : phase_pct[p];
                random_batch();
                if ($urandom_range(19) == 0)
                    wait_results_in();
            end
            wait_results_in();
        end

        // drain and settle
        idle_pct = 0;
        wait_results_in();
        repeat (SETTLE) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            $error("%0d batch results never arrived", tracker.pending());
            tracker.mismatches++;
        end
        $display("tb_top: %0d batches closed (%0d random transactions),",
                 batches_sent, rand_items);
        $display("tb_top: %0d results checked incl. empty, tie and overflow batches",
                 tracker.results_checked);
        if (tracker.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
